/* hw/rtl/limit_switch_lifter_controller_defines.svh */
// Assertion macros for the limit-switch lifter controller checker.
// No dependencies; included by the checker module.
`ifndef LIMIT_SWITCH_LIFTER_CONTROLLER_DEFINES_SVH
`define LIMIT_SWITCH_LIFTER_CONTROLLER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LSLC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define LSLC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked across reset.
`define LSLC_ASSERT_ALWAYS_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/lslc_pkg.sv */
// Shared types and constants of the limit-switch lifter controller.
// No dependencies; used by the top level and its checker.
package lslc_pkg;

  localparam int unsigned CFG_W       = 16;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned TIMER_BITS  = 16;

  localparam logic [CFG_W-1:0] MOVE_TIMEOUT_RST  = CFG_W'(14 * 1000);
  localparam logic [CFG_W-1:0] LEAVE_TIMEOUT_RST = CFG_W'(1000);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REVERSE_POLARITY = 2'd0,
    CFG_SLEEP_MODE       = 2'd1,
    CFG_MOVE_TIMEOUT     = 2'd2,
    CFG_LEAVE_TIMEOUT    = 2'd3
  } lslc_cfg_idx_t;

  typedef enum logic [1:0] {
    KIND_TICK      = 2'd0,
    KIND_CMD       = 2'd1,
    KIND_DOWN_EDGE = 2'd2,
    KIND_UP_EDGE   = 2'd3
  } lslc_kind_t;

  localparam logic [2:0] POS_DOWN    = 3'd0;
  localparam logic [2:0] POS_UP      = 3'd1;
  localparam logic [2:0] POS_MOVING  = 3'd2;
  localparam logic [2:0] POS_NEITHER = 3'd3;
  localparam logic [2:0] POS_BOTH    = 3'd4;

  localparam logic [2:0] EVT_NONE        = 3'd0;
  localparam logic [2:0] EVT_RAISE_START = 3'd1;
  localparam logic [2:0] EVT_LOWER_START = 3'd2;
  localparam logic [2:0] EVT_REACHED_DN  = 3'd3;
  localparam logic [2:0] EVT_REACHED_UP  = 3'd4;
  localparam logic [2:0] EVT_TIMEOUT     = 3'd5;

  localparam logic [1:0] FLT_NONE        = 2'd0;
  localparam logic [1:0] FLT_UP_NOT_LEFT = 2'd1;
  localparam logic [1:0] FLT_DN_NOT_LEFT = 2'd2;
  localparam logic [1:0] FLT_BOTH_ACTIVE = 2'd3;

endpackage

/* hw/rtl/limit_switch_lifter_controller.sv */
// Lifter motor controller: one transaction in, one result transaction out.
// Depends on lslc_pkg.
//
// Each result is registered and appears in the cycle after its item is accepted.
// Throughput: one item per cycle; the result register stalls input only when
// it holds a result that is not taken in the same cycle.
// Reset (rst_n low, synchronous): motor off, timers disarmed, registers at
// their defaults (move timeout 14000 ticks, leave timeout 1000 ticks).
module limit_switch_lifter_controller #(
  parameter int unsigned TIMER_BITS = lslc_pkg::TIMER_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Configuration
  input  logic                           cfg_we,
  input  logic [lslc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lslc_pkg::CFG_W-1:0]     cfg_wdata,
  // Input channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_kind,
  input  logic                           in_target,
  input  logic                           in_down_limit,
  input  logic                           in_up_limit,
  // Result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_drive_forward,
  output logic                           out_drive_reverse,
  output logic [2:0]                     out_position_code,
  output logic [2:0]                     out_event_code,
  output logic [1:0]                     out_fault_code,
  output logic                           out_started
);

  localparam int unsigned CW = lslc_pkg::CFG_W;

  // Configuration registers
  logic          reverse_polarity_r;
  logic          sleep_mode_r;
  logic [CW-1:0] move_timeout_r;
  logic [CW-1:0] leave_timeout_r;

  // Controller state
  logic                  moving_r,       moving_nxt;
  logic [1:0]            drive_r,        drive_nxt;
  logic [TIMER_BITS-1:0] move_timer_r,   move_timer_nxt;
  logic                  move_armed_r,   move_armed_nxt;
  logic [TIMER_BITS-1:0] leave_timer_r,  leave_timer_nxt;
  logic                  leave_armed_r,  leave_armed_nxt;
  logic                  leave_dir_r,    leave_dir_nxt;

  // Result register
  logic       out_valid_r;
  logic [1:0] out_drive_r;
  logic [2:0] out_pos_r;
  logic [2:0] out_evt_r;
  logic [1:0] out_flt_r;
  logic       out_started_r;

  logic       accept;
  logic [2:0] pos_nxt;
  logic [2:0] evt_nxt;
  logic [1:0] flt_nxt;
  logic       started_nxt;
  logic       fwd;
  logic       hit;

  logic [TIMER_BITS-1:0] move_load;
  logic [TIMER_BITS-1:0] leave_load;

  // Timeouts are saturated to the timer width when the timer is narrower.
  generate
    if (TIMER_BITS >= CW) begin : g_wide_timer
      assign move_load  = TIMER_BITS'(move_timeout_r);
      assign leave_load = TIMER_BITS'(leave_timeout_r);
    end else begin : g_narrow_timer
      assign move_load  = (|move_timeout_r[CW-1:TIMER_BITS]) ? '1
                                                              : move_timeout_r[TIMER_BITS-1:0];
      assign leave_load = (|leave_timeout_r[CW-1:TIMER_BITS]) ? '1
                                                               : leave_timeout_r[TIMER_BITS-1:0];
    end
  endgenerate

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reverse_polarity_r <= 1'b0;
      sleep_mode_r       <= 1'b0;
      move_timeout_r     <= lslc_pkg::MOVE_TIMEOUT_RST;
      leave_timeout_r    <= lslc_pkg::LEAVE_TIMEOUT_RST;
    end else if (cfg_we) begin
      case (lslc_pkg::lslc_cfg_idx_t'(cfg_index))
        lslc_pkg::CFG_REVERSE_POLARITY: reverse_polarity_r <= cfg_wdata[0];
        lslc_pkg::CFG_SLEEP_MODE:       sleep_mode_r       <= cfg_wdata[0];
        lslc_pkg::CFG_MOVE_TIMEOUT:     move_timeout_r     <= cfg_wdata;
        lslc_pkg::CFG_LEAVE_TIMEOUT:    leave_timeout_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    moving_nxt      = moving_r;
    drive_nxt       = drive_r;
    move_timer_nxt  = move_timer_r;
    move_armed_nxt  = move_armed_r;
    leave_timer_nxt = leave_timer_r;
    leave_armed_nxt = leave_armed_r;
    leave_dir_nxt   = leave_dir_r;
    evt_nxt         = lslc_pkg::EVT_NONE;
    flt_nxt         = lslc_pkg::FLT_NONE;
    started_nxt     = 1'b0;
    fwd             = in_target ^ reverse_polarity_r;
    hit             = 1'b0;

    case (lslc_pkg::lslc_kind_t'(in_kind))
      lslc_pkg::KIND_TICK: begin
        if (move_armed_r) begin
          // A count of zero or one expires on this tick.
          if (move_timer_r[TIMER_BITS-1:1] == '0) begin
            move_timer_nxt = '0;
            move_armed_nxt = 1'b0;
            drive_nxt      = 2'b00;
            moving_nxt     = 1'b0;
            evt_nxt        = lslc_pkg::EVT_TIMEOUT;
          end else begin
            move_timer_nxt = move_timer_r - 1'b1;
          end
        end
        if (leave_armed_r) begin
          if (leave_timer_r[TIMER_BITS-1:1] == '0) begin
            leave_timer_nxt = '0;
            leave_armed_nxt = 1'b0;
            if (!leave_dir_r && in_up_limit) begin
              flt_nxt = lslc_pkg::FLT_UP_NOT_LEFT;
            end else if (leave_dir_r && in_down_limit) begin
              flt_nxt = lslc_pkg::FLT_DN_NOT_LEFT;
            end
          end else begin
            leave_timer_nxt = leave_timer_r - 1'b1;
          end
        end
      end
      lslc_pkg::KIND_CMD: begin
        if (!sleep_mode_r) begin
          if (!moving_r && in_down_limit && in_up_limit) begin
            flt_nxt = lslc_pkg::FLT_BOTH_ACTIVE;
          end else if (moving_r || (in_target ? !in_up_limit : !in_down_limit)) begin
            // While moving the position never equals the target, so it restarts.
            moving_nxt      = 1'b1;
            drive_nxt       = fwd ? 2'b01 : 2'b10;
            leave_dir_nxt   = in_target;
            leave_timer_nxt = leave_load;
            leave_armed_nxt = 1'b1;
            move_timer_nxt  = move_load;
            move_armed_nxt  = 1'b1;
            evt_nxt         = in_target ? lslc_pkg::EVT_RAISE_START
                                        : lslc_pkg::EVT_LOWER_START;
            started_nxt     = 1'b1;
          end
        end
      end
      lslc_pkg::KIND_DOWN_EDGE, lslc_pkg::KIND_UP_EDGE: begin
        hit = (in_kind == lslc_pkg::KIND_DOWN_EDGE) ? in_down_limit : in_up_limit;
        if (hit) begin
          move_timer_nxt = '0;
          move_armed_nxt = 1'b0;
          drive_nxt      = 2'b00;
          moving_nxt     = 1'b0;
          evt_nxt        = (in_kind == lslc_pkg::KIND_DOWN_EDGE) ? lslc_pkg::EVT_REACHED_DN
                                                                 : lslc_pkg::EVT_REACHED_UP;
        end
      end
      default: ;
    endcase

    if (moving_nxt) begin
      pos_nxt = lslc_pkg::POS_MOVING;
    end else if (in_down_limit && in_up_limit) begin
      pos_nxt = lslc_pkg::POS_BOTH;
    end else if (in_down_limit) begin
      pos_nxt = lslc_pkg::POS_DOWN;
    end else if (in_up_limit) begin
      pos_nxt = lslc_pkg::POS_UP;
    end else begin
      pos_nxt = lslc_pkg::POS_NEITHER;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      moving_r      <= 1'b0;
      drive_r       <= 2'b00;
      move_timer_r  <= '0;
      move_armed_r  <= 1'b0;
      leave_timer_r <= '0;
      leave_armed_r <= 1'b0;
      leave_dir_r   <= 1'b0;
    end else if (accept) begin
      moving_r      <= moving_nxt;
      drive_r       <= drive_nxt;
      move_timer_r  <= move_timer_nxt;
      move_armed_r  <= move_armed_nxt;
      leave_timer_r <= leave_timer_nxt;
      leave_armed_r <= leave_armed_nxt;
      leave_dir_r   <= leave_dir_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_drive_r   <= drive_nxt;
      out_pos_r     <= pos_nxt;
      out_evt_r     <= evt_nxt;
      out_flt_r     <= flt_nxt;
      out_started_r <= started_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_drive_forward = out_drive_r[0];
  assign out_drive_reverse = out_drive_r[1];
  assign out_position_code = out_pos_r;
  assign out_event_code    = out_evt_r;
  assign out_fault_code    = out_flt_r;
  assign out_started       = out_started_r;

endmodule

/* hw/rtl/lslc_checker.sv */
// Port-level checks for the lifter controller, bound to the top level.
// Depends on lslc_pkg and limit_switch_lifter_controller_defines.svh.
`include "limit_switch_lifter_controller_defines.svh"

module lslc_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           cfg_we,
  input logic [lslc_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [lslc_pkg::CFG_W-1:0]     cfg_wdata,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic [1:0]                     in_kind,
  input logic                           in_target,
  input logic                           in_down_limit,
  input logic                           in_up_limit,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic                           out_drive_forward,
  input logic                           out_drive_reverse,
  input logic [2:0]                     out_position_code,
  input logic [2:0]                     out_event_code,
  input logic [1:0]                     out_fault_code,
  input logic                           out_started
);

  // A waiting result transaction keeps its payload until it is taken.
  `LSLC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_drive_forward) && $stable(out_drive_reverse) && $stable(out_position_code) && $stable(out_event_code) && $stable(out_fault_code) && $stable(out_started), "result changed while stalled")

  // The motor runs in exactly the cases the position reads as moving.
  `LSLC_ASSERT_NOW(a_drive_moving, out_valid, ((out_drive_forward || out_drive_reverse) == (out_position_code == lslc_pkg::POS_MOVING)) && !(out_drive_forward && out_drive_reverse), "drive and moving position disagree")

  // A started move reports a start event and leaves the motor running.
  `LSLC_ASSERT_NOW(a_start_event, out_valid && out_started, (out_event_code == lslc_pkg::EVT_RAISE_START || out_event_code == lslc_pkg::EVT_LOWER_START) && out_fault_code == lslc_pkg::FLT_NONE && out_position_code == lslc_pkg::POS_MOVING, "start without start event")

  // No result is presented right after reset.
  `LSLC_ASSERT_ALWAYS_NEXT(a_reset_empty, !rst_n, !out_valid, "result valid after reset")

endmodule

bind limit_switch_lifter_controller lslc_checker u_lslc_checker (.*);
